FILE: src/scd_pkg.sv
`timescale 1ns / 1ps

package scd_pkg;

  // sector geometry and address widths
  localparam int SECTOR_BYTES = 512;
  localparam int OFF_W        = $clog2(SECTOR_BYTES);
  localparam int LOC_W        = 48;
  localparam int SECT_W       = LOC_W - OFF_W;
  localparam int DRV_W        = 2;
  localparam int DRIVE_COUNT  = 4;

  // byte gathering: up to eight bytes per read
  localparam int CNT_W  = 4;
  localparam int LANE_W = 3;

  // bios drive numbering
  localparam logic [7:0] BIOS_BASE = 8'h80;
  localparam logic [7:0] BIOS_TOP  = 8'(BIOS_BASE + DRIVE_COUNT - 1);

  // input action codes
  localparam logic ACT_READ = 1'b0;
  localparam logic ACT_FILL = 1'b1;

  // result kind codes
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // access to the sector buffer for one cycle
  typedef struct packed {
    logic             we;
    logic [OFF_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [OFF_W-1:0] raddr;
  } scd_ram_req_t;

endpackage

FILE: src/sector_cached_disk_reader_top.sv
`timescale 1ns / 1ps
// channel   direction  ports                                            transfer when
// in        input      in_action in_drive_index in_location             in_valid & in_ready
//                      in_read_size in_fill_byte
// out       output     out_kind out_physical_drive out_sector_number    out_valid & out_ready
//                      out_read_value
// cfg       input      cfg_wr_en cfg_wr_data (boot drive)               cfg_wr_en
//
// A read takes one byte per cycle from the byte-wide sector buffer while the cursor hits, and
// registers the result after the last buffer read returns, once the output is free.
// A miss sends a load request and then takes one fill byte per transfer, 512 per sector.
// Synchronous active-low reset empties the cache; the buffer contents need no clearing.
// A waiting result holds back the next result; inputs are taken in idle and while loading.

module sector_cached_disk_reader_top
  import scd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  logic [DRV_W-1:0]  in_drive_index,
  input  logic [LOC_W-1:0]  in_location,
  input  logic [1:0]        in_read_size,
  input  logic [7:0]        in_fill_byte,

  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [7:0]        out_physical_drive,
  output logic [SECT_W-1:0] out_sector_number,
  output logic [63:0]       out_read_value,

  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_GATHER = 3'b010,
    ST_LOAD   = 3'b100
  } scd_state_t;

  scd_state_t         state_r, state_nxt;
  logic [7:0]         boot_r;
  logic               buf_valid_r, buf_valid_nxt;
  logic [DRV_W-1:0]   tag_drive_r, tag_drive_nxt;
  logic [SECT_W-1:0]  tag_sector_r, tag_sector_nxt;
  logic [OFF_W-1:0]   fill_cnt_r, fill_cnt_nxt;
  logic [LOC_W-1:0]   cursor_r, cursor_nxt;
  logic [DRV_W-1:0]   cur_drive_r, cur_drive_nxt;
  logic [CNT_W-1:0]   wanted_r, wanted_nxt;
  logic [CNT_W-1:0]   issue_cnt_r, issue_cnt_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic [LANE_W-1:0]  rd_lane_r, rd_lane_nxt;
  logic [63:0]        partial_r, partial_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_kind_r, out_kind_nxt;
  logic [7:0]         out_drive_r, out_drive_nxt;
  logic [SECT_W-1:0]  out_sector_r, out_sector_nxt;
  logic [63:0]        out_value_r, out_value_nxt;

  scd_ram_req_t       ram_req;
  logic [7:0]         ram_rd_data;

  logic               in_xfer;
  logic               hit;
  logic               more;
  logic               out_free;

  // logical to bios drive map, boot drive first
  function automatic logic [7:0] map_drive(input logic [7:0] boot_raw,
                                           input logic [DRV_W-1:0] logical);
    logic [7:0] boot;
    logic [7:0] phys;
    boot = boot_raw;
    if (boot < BIOS_BASE) begin
      boot = BIOS_BASE;
    end
    if (boot > BIOS_TOP) begin
      boot = BIOS_TOP;
    end
    phys = 8'(BIOS_BASE + 8'(logical) - 8'd1);
    if (phys >= boot) begin
      phys = 8'(phys + 8'd1);
    end
    return (logical == '0) ? boot : phys;
  endfunction

  scd_sector_buf u_buf (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  // handshake and lookup
  assign in_ready = (state_r == ST_IDLE) || (state_r == ST_LOAD);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign more     = issue_cnt_r < wanted_r;
  assign hit      = buf_valid_r && (tag_drive_r == cur_drive_r) &&
                    (tag_sector_r == cursor_r[LOC_W-1:OFF_W]);

  // next state
  always_comb begin
    state_nxt      = state_r;
    buf_valid_nxt  = buf_valid_r;
    tag_drive_nxt  = tag_drive_r;
    tag_sector_nxt = tag_sector_r;
    fill_cnt_nxt   = fill_cnt_r;
    cursor_nxt     = cursor_r;
    cur_drive_nxt  = cur_drive_r;
    wanted_nxt     = wanted_r;
    issue_cnt_nxt  = issue_cnt_r;
    rd_pend_nxt    = 1'b0;
    rd_lane_nxt    = rd_lane_r;
    partial_nxt    = partial_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_drive_nxt  = out_drive_r;
    out_sector_nxt = out_sector_r;
    out_value_nxt  = out_value_r;
    ram_req        = '0;

    // buffer byte returning from last cycle's read
    if (rd_pend_r) begin
      partial_nxt[8*rd_lane_r +: 8] = ram_rd_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_action == ACT_READ)) begin
          cur_drive_nxt = in_drive_index;
          cursor_nxt    = in_location;
          wanted_nxt    = CNT_W'(1) << in_read_size;
          issue_cnt_nxt = '0;
          partial_nxt   = '0;
          state_nxt     = ST_GATHER;
        end
      end

      ST_GATHER: begin
        if (more && hit) begin
          // read one byte, advance the cursor
          ram_req.re    = 1'b1;
          ram_req.raddr = cursor_r[OFF_W-1:0];
          rd_pend_nxt   = 1'b1;
          rd_lane_nxt   = issue_cnt_r[LANE_W-1:0];
          issue_cnt_nxt = issue_cnt_r + CNT_W'(1);
          cursor_nxt    = cursor_r + LOC_W'(1);
        end else if (more && out_free) begin
          // miss: ask for the sector
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_LOAD;
          out_drive_nxt  = map_drive(boot_r, cur_drive_r);
          out_sector_nxt = cursor_r[LOC_W-1:OFF_W];
          out_value_nxt  = '0;
          fill_cnt_nxt   = '0;
          state_nxt      = ST_LOAD;
        end else if (!more && !rd_pend_r && out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_DATA;
          out_drive_nxt  = '0;
          out_sector_nxt = '0;
          out_value_nxt  = partial_r;
          state_nxt      = ST_IDLE;
        end
      end

      ST_LOAD: begin
        if (in_xfer && (in_action == ACT_FILL)) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = fill_cnt_r;
          ram_req.wdata = in_fill_byte;
          fill_cnt_nxt  = fill_cnt_r + OFF_W'(1);
          // last fill byte: retag and resume the read
          if (fill_cnt_r == OFF_W'(SECTOR_BYTES - 1)) begin
            buf_valid_nxt  = 1'b1;
            tag_drive_nxt  = cur_drive_r;
            tag_sector_nxt = cursor_r[LOC_W-1:OFF_W];
            state_nxt      = ST_GATHER;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      boot_r       <= BIOS_BASE;
      buf_valid_r  <= 1'b0;
      tag_drive_r  <= '0;
      tag_sector_r <= '0;
      fill_cnt_r   <= '0;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_wr_en) begin
        boot_r <= cfg_wr_data;
      end
      buf_valid_r  <= buf_valid_nxt;
      tag_drive_r  <= tag_drive_nxt;
      tag_sector_r <= tag_sector_nxt;
      fill_cnt_r   <= fill_cnt_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cursor_r     <= cursor_nxt;
    cur_drive_r  <= cur_drive_nxt;
    wanted_r     <= wanted_nxt;
    issue_cnt_r  <= issue_cnt_nxt;
    rd_lane_r    <= rd_lane_nxt;
    partial_r    <= partial_nxt;
    out_kind_r   <= out_kind_nxt;
    out_drive_r  <= out_drive_nxt;
    out_sector_r <= out_sector_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_physical_drive = out_drive_r;
  assign out_sector_number  = out_sector_r;
  assign out_read_value     = out_value_r;

endmodule

FILE: src/scd_sector_buf.sv
`timescale 1ns / 1ps

module scd_sector_buf
  import scd_pkg::*;
(
  input  logic         clk,
  input  scd_ram_req_t req,
  output logic [7:0]   rd_data
);

  logic [7:0] mem [SECTOR_BYTES];
  logic [7:0] rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
